[rtl/kcd_pkg.sv]
// kcd_pkg: shared constants, codes and types for the key click detector
// no dependencies; imported by key_click_double_long_detector_top
package kcd_pkg;

  // tick counter and configuration register widths
  localparam int unsigned CountWidth = 16;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CmpWidth   = (CountWidth > CfgWidth) ? CountWidth : CfgWidth;

  // register reset values
  localparam logic [CfgWidth-1:0] DebounceReset = CfgWidth'(5);
  localparam logic [CfgWidth-1:0] LongReset     = CfgWidth'(400);
  localparam logic [CfgWidth-1:0] MinClickReset = CfgWidth'(5);
  localparam logic [CfgWidth-1:0] WindowReset   = CfgWidth'(38);

  // register indexes
  localparam logic [CfgIdxWidth-1:0] RegDebounce = CfgIdxWidth'(0);
  localparam logic [CfgIdxWidth-1:0] RegLong     = CfgIdxWidth'(1);
  localparam logic [CfgIdxWidth-1:0] RegMinClick = CfgIdxWidth'(2);
  localparam logic [CfgIdxWidth-1:0] RegWindow   = CfgIdxWidth'(3);

  // reported event codes
  typedef enum logic [1:0] {
    EvNone   = 2'd0,
    EvClick  = 2'd1,
    EvDouble = 2'd2,
    EvLong   = 2'd3
  } key_event_e;

  // sequencer steps, one-hot
  typedef enum logic [5:0] {
    StIdle     = 6'b000001,
    StDebounce = 6'b000010,
    StHold     = 6'b000100,
    StClassify = 6'b001000,
    StWindow   = 6'b010000,
    StSecond   = 6'b100000
  } step_e;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [CfgWidth-1:0]   cfg_t;

endpackage

[rtl/key_click_double_long_detector_top.sv]
// key_click_double_long_detector_top: click / double click / long press detector
// depends on kcd_pkg
//
// Usage: each input word is one timer tick carrying the sampled button level
// (key_pressed_i). Every accepted tick produces exactly one output word whose
// key_event_o is none, click, double click or long press.
// Channels use valid/stall: a word moves on a rising edge with valid high and
// stall low. Configuration is a plain write port (cfg_we_i, cfg_index_i,
// cfg_data_i); indexes 0..3 select debounce, long press, minimum click and
// double-click window tick counts, higher indexes are ignored. Write only
// while the block holds no word.
// Path: an accepted tick is held in the input register, and its result is then
// registered in the result register, which drives the output word.
// Throughput: one tick per cycle while the output is not stalled; the sequencer
// and counter update as the tick moves from the input register to the result register.
// Reset clears the sequencer to idle, the tick counter to zero, restores the
// register defaults and empties both registers.
// When the receiver stalls, the result word holds, the input register keeps
// one more tick, and then in_stall_o rises until the output drains.
module key_click_double_long_detector_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           key_pressed_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     key_event_o,
  input  logic                           cfg_we_i,
  input  logic [kcd_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [kcd_pkg::CfgWidth-1:0]   cfg_data_i
);
  import kcd_pkg::*;

  localparam count_t CountMax = {CountWidth{1'b1}};

  cfg_t       debounce_q, long_q, min_click_q, window_q;
  logic       in_valid_q;
  logic       key_q;
  logic       out_valid_q;
  key_event_e event_q, event_d;
  step_e      step_q, step_d;
  count_t     count_q, count_d;
  count_t     count_inc;
  logic       advance;
  logic       debounce_hit, window_hit, long_hit, click_hit;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DebounceReset;
      long_q      <= LongReset;
      min_click_q <= MinClickReset;
      window_q    <= WindowReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegDebounce: debounce_q  <= cfg_data_i;
        RegLong:     long_q      <= cfg_data_i;
        RegMinClick: min_click_q <= cfg_data_i;
        RegWindow:   window_q    <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // handshake: the result register takes a word when empty or draining
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      key_q <= key_pressed_i;
    end
  end

  // saturating increment and timed compares
  assign count_inc    = (count_q == CountMax) ? count_q : count_q + count_t'(1);
  assign debounce_hit = (CmpWidth'(count_inc) >= CmpWidth'(debounce_q)) ||
                        (count_inc == CountMax);
  assign window_hit   = (CmpWidth'(count_inc) >= CmpWidth'(window_q)) ||
                        (count_inc == CountMax);
  assign long_hit     = CmpWidth'(count_q) > CmpWidth'(long_q);
  assign click_hit    = CmpWidth'(count_q) > CmpWidth'(min_click_q);

  // sequencer step for the tick in the input register
  always_comb begin
    step_d  = step_q;
    count_d = count_q;
    event_d = EvNone;
    unique case (step_q)
      StIdle: begin
        if (key_q) step_d = StDebounce;
      end
      StDebounce: begin
        count_d = count_inc;
        if (debounce_hit) begin
          count_d = '0;
          step_d  = key_q ? StHold : StIdle;
        end
      end
      StHold: begin
        if (key_q) count_d = count_inc;
        else       step_d  = StClassify;
      end
      StClassify: begin
        count_d = '0;
        if (long_hit) begin
          step_d  = StIdle;
          event_d = EvLong;
        end else if (click_hit) begin
          step_d = StWindow;
        end else begin
          step_d = StIdle;
        end
      end
      StWindow: begin
        count_d = count_inc;
        if (window_hit) begin
          count_d = '0;
          if (key_q) begin
            step_d = StSecond;
          end else begin
            step_d  = StIdle;
            event_d = EvClick;
          end
        end
      end
      StSecond: begin
        if (key_q) begin
          count_d = count_inc;
        end else begin
          count_d = '0;
          step_d  = StIdle;
          event_d = EvDouble;
        end
      end
      default: begin
        count_d = '0;
        step_d  = StIdle;
      end
    endcase
  end

  // sequencer state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        step_q  <= step_d;
        count_q <= count_d;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      event_q <= event_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_event_o = event_q;

endmodule

[rtl/kcd_checker.sv]
// kcd_checker: port-level assertions for the key click detector
// depends on key_click_double_long_detector_top (bound below)
module kcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] key_event_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(key_event_o))
    else $error("stalled result word changed");

  // input stalls only when the output is full and blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output could drain");

  // an accepted tick reaches the output through the input and result registers when nothing blocks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_stall_i) ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted tick did not produce a result word");

endmodule

bind key_click_double_long_detector_top kcd_checker u_kcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .key_event_o (key_event_o)
);
